/* rtl/core/wsdf_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

    localparam logic [7:0] OPC_TEXT   = 8'h81;
    localparam logic [7:0] OPC_BINARY = 8'h82;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // last header byte index in each header section
    localparam logic [2:0] HPOS_EXT16_LAST = 3'd1;
    localparam logic [2:0] HPOS_EXT64_LAST = 3'd7;
    localparam logic [2:0] HPOS_MASK_LAST  = 3'd3;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic [1:0] kind;
        logic       binary;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_item;

endpackage

/* rtl/core/websocket_frame_deframer_core.sv */
// WebSocket receive deframer: takes one stream byte per cycle and gives out unmasked
// payload bytes, empty-frame marks and invalid-opcode errors. A byte is taken every
// cycle while o_stall is low; each result is registered before it reaches the output.
// The output side is a result register backed by one skid entry, so the input keeps
// flowing while a single result waits; o_stall rises only when both are occupied.
// The payload counter is LENGTH_BITS wide and keeps the low bits of the received length.
module websocket_frame_deframer_core #(
    parameter int LENGTH_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_data_byte,
    output logic       o_last,
    output logic [1:0] o_kind,
    output logic       o_binary
);
    import wsdf_pkg::*;

    logic    accept;
    logic    full;
    t_item   item;
    t_result res;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    wsdf_parse #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in_byte(i_in_byte),
        .o_item   (item)
    );

    wsdf_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_item (item),
        .i_stall(i_stall),
        .o_full (full),
        .o_valid(o_valid),
        .o_res  (res)
    );

    assign o_data_byte = res.data_byte;
    assign o_last      = res.last;
    assign o_kind      = res.kind;
    assign o_binary    = res.binary;

endmodule

/* rtl/core/wsdf_parse.sv */
// Frame header parser and payload unmasking state machine.
module wsdf_parse #(
    parameter int LENGTH_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    output wsdf_pkg::t_item o_item
);
    import wsdf_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_LEN,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_PAYLOAD
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [2:0]             r_hpos, n_hpos;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [31:0]            r_key, n_key;
    logic [1:0]             r_midx, n_midx;
    logic                   r_bin, n_bin;

    logic [6:0] len7;
    logic [7:0] key_byte;
    t_item      item;

    assign len7 = i_in_byte[6:0];

    always_comb begin
        case (r_midx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_rem   = r_rem;
        n_key   = r_key;
        n_midx  = r_midx;
        n_bin   = r_bin;
        item    = '0;
        if (i_accept) begin
            case (r_phase)
                PH_FIRST: begin
                    if (i_in_byte == OPC_TEXT || i_in_byte == OPC_BINARY) begin
                        n_bin   = (i_in_byte == OPC_BINARY);
                        n_phase = PH_LEN;
                    end else begin
                        item.valid    = 1'b1;
                        item.res.kind = KIND_INVALID;
                    end
                end
                PH_LEN: begin
                    n_hpos = '0;
                    n_rem  = '0;
                    if (len7 == LEN7_EXT16) begin
                        n_phase = PH_EXT16;
                    end else if (len7 == LEN7_EXT64) begin
                        n_phase = PH_EXT64;
                    end else begin
                        n_rem   = LENGTH_BITS'(len7);
                        n_phase = PH_MASK;
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    n_rem  = {r_rem[LENGTH_BITS-9:0], i_in_byte};
                    n_hpos = r_hpos + 3'd1;
                    if (r_hpos == ((r_phase == PH_EXT16) ? HPOS_EXT16_LAST
                                                          : HPOS_EXT64_LAST)) begin
                        n_hpos  = '0;
                        n_phase = PH_MASK;
                    end
                end
                PH_MASK: begin
                    n_key  = {r_key[23:0], i_in_byte};
                    n_hpos = r_hpos + 3'd1;
                    if (r_hpos == HPOS_MASK_LAST) begin
                        n_hpos = '0;
                        n_midx = '0;
                        if (r_rem == '0) begin
                            n_phase         = PH_FIRST;
                            item.valid      = 1'b1;
                            item.res.last   = 1'b1;
                            item.res.kind   = KIND_EMPTY;
                            item.res.binary = r_bin;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_midx             = r_midx + 2'd1;
                    n_rem              = r_rem - LENGTH_BITS'(1);
                    item.valid         = 1'b1;
                    item.res.data_byte = i_in_byte ^ key_byte;
                    item.res.last      = (r_rem == LENGTH_BITS'(1));
                    item.res.kind      = KIND_PAYLOAD;
                    item.res.binary    = r_bin;
                    if (r_rem == LENGTH_BITS'(1)) begin
                        n_phase = PH_FIRST;
                    end
                end
                default: begin
                    n_phase = PH_FIRST;
                    n_hpos  = '0;
                    n_rem   = '0;
                    n_key   = '0;
                    n_midx  = '0;
                    n_bin   = 1'b0;
                end
            endcase
        end
    end

    assign o_item = item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_hpos  <= '0;
            r_rem   <= '0;
            r_key   <= '0;
            r_midx  <= '0;
            r_bin   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_rem   <= n_rem;
            r_key   <= n_key;
            r_midx  <= n_midx;
            r_bin   <= n_bin;
        end
    end

endmodule

/* rtl/core/wsdf_obuf.sv */
// Result register with a skid entry for the output channel.
module wsdf_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wsdf_pkg::t_item   i_item,
    input  logic              i_stall,
    output logic              o_full,
    output logic              o_valid,
    output wsdf_pkg::t_result o_res
);
    import wsdf_pkg::*;

    logic    r_out_v, n_out_v;
    logic    r_skid_v, n_skid_v;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_out_v && !i_stall;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        n_out    = r_out;
        n_skid   = r_skid;
        if (r_skid_v) begin
            if (pop) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (!r_out_v || pop) begin
            n_out_v = i_item.valid;
            if (i_item.valid) begin
                n_out = i_item.res;
            end
        end else if (i_item.valid) begin
            n_skid   = i_item.res;
            n_skid_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

/* rtl/core/wsdf_chk.sv */
// Port-level assertions for the deframer and their bind to the top level.
module wsdf_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_data_byte,
    input logic       o_last,
    input logic [1:0] o_kind,
    input logic       o_binary
);
    import wsdf_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data_byte) && $stable(o_last)
                                  && $stable(o_kind) && $stable(o_binary)))
        else $error("stalled result changed");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind == KIND_PAYLOAD || o_kind == KIND_EMPTY
                     || o_kind == KIND_INVALID))
        else $error("illegal result kind");

    a_invalid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_INVALID) |-> (!o_last && !o_binary
                                                 && o_data_byte == 8'd0))
        else $error("invalid-opcode result carries data");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_EMPTY) |-> (o_last && o_data_byte == 8'd0))
        else $error("empty-frame result malformed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("outputs active after reset");

endmodule

bind websocket_frame_deframer_core wsdf_chk u_wsdf_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_data_byte(o_data_byte),
    .o_last     (o_last),
    .o_kind     (o_kind),
    .o_binary   (o_binary)
);
